// File: rtl/pist_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-solid test package
// Shared constants, register codes and stage record types.
// ----------------------------------------------------------------------------
package pist_pkg;

  // Coordinate width (signed Q16.16) and bump fixed-point one (Q1.14).
  localparam int          CW      = 32;
  localparam logic [14:0] QONE15  = 15'd16384;
  localparam logic [15:0] QONE16  = 16'd16384;

  // Solid selection codes; the two remaining codes accept every point.
  typedef enum logic [2:0] {
    SHAPE_BOX      = 3'd0,
    SHAPE_PYRAMID  = 3'd1,
    SHAPE_CONE     = 3'd2,
    SHAPE_SPHERE   = 3'd3,
    SHAPE_CYLINDER = 3'd4,
    SHAPE_BUMP     = 3'd5
  } shape_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SHAPE_MODE  = 3'd0,
    REG_BOUND_X_MIN = 3'd1,
    REG_BOUND_X_MAX = 3'd2,
    REG_BOUND_Y_MIN = 3'd3,
    REG_BOUND_Y_MAX = 3'd4,
    REG_BOUND_Z_MIN = 3'd5,
    REG_BOUND_Z_MAX = 3'd6,
    REG_BUMP_PARAMS = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]    shape_mode;
    logic [CW-1:0] x_min;
    logic [CW-1:0] x_max;
    logic [CW-1:0] y_min;
    logic [CW-1:0] y_max;
    logic [CW-1:0] z_min;
    logic [CW-1:0] z_max;
    logic [63:0]   bump;
  } cfg_t;

  // Offsets, spans and bump terms after the first stage.
  typedef struct packed {
    logic [33:0] ax;
    logic [33:0] ay;
    logic [33:0] az;
    logic [31:0] hu;
    logic [31:0] hxm;
    logic [31:0] hym;
    logic        hxneg;
    logic        hyneg;
    logic [32:0] rmag;
    logic [31:0] up;
    logic [31:0] u;
    logic        ge;
    logic        inz;
    logic [14:0] b;
    logic [14:0] rx;
    logic [14:0] ry;
    logic [28:0] kk;
    logic        active;
  } prep_t;

  // Products after the second stage.
  typedef struct packed {
    logic [67:0] sqx;
    logic [67:0] sqy;
    logic [67:0] sqz;
    logic [63:0] hsq;
    logic [65:0] rsq;
    logic [64:0] tt;
    logic [65:0] pxl;
    logic [65:0] pyl;
    logic [63:0] pxr;
    logic [63:0] pyr;
    logic [46:0] bxr;
    logic [46:0] byr;
    logic [46:0] bbh;
    logic [60:0] hk;
    logic [33:0] ax;
    logic [33:0] ay;
    logic [31:0] u;
    logic        axz;
    logic        ayz;
    logic        upz;
    logic        rxz;
    logic        ryz;
    logic        hxneg;
    logic        hyneg;
    logic        inz;
    logic        ge;
    logic        active;
  } prod_t;

  // Decision record after the third stage; the cone test still needs
  // its wide products.
  typedef struct packed {
    logic        res;
    logic        cone_sel;
    logic        inz;
    logic [68:0] rr;
    logic [63:0] hsq;
    logic [64:0] tt;
  } dec_t;

endpackage

// File: rtl/pist_prep.sv
// ----------------------------------------------------------------------------
// Point-in-solid test: offset stage
// Forms doubled offsets, spans, z checks and the clamped bump terms.
// ----------------------------------------------------------------------------
module pist_prep
  import pist_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  cfg_t          cfg,
  input  logic [CW-1:0] px,
  input  logic [CW-1:0] py,
  input  logic [CW-1:0] pz,
  output prep_t         q_r
);

  prep_t       q_nxt;
  logic [32:0] h;
  logic [32:0] hx2;
  logic [32:0] hy2;
  logic [32:0] r2s;
  logic [33:0] dx2;
  logic [33:0] dy2;
  logic [33:0] dz2;
  logic [32:0] up_w;
  logic [32:0] u_w;
  logic        inz;
  logic        ge;
  logic [15:0] mf;
  logic [15:0] mneg_abs;
  logic [14:0] mabs;
  logic        mneg;
  logic [29:0] kneg;
  logic [29:0] kpos;

  function automatic logic [14:0] clamp01(input logic [15:0] f);
    logic [14:0] r;
    if (f[15]) begin
      r = 15'd0;
    end else if (f > QONE16) begin
      r = QONE15;
    end else begin
      r = f[14:0];
    end
    return r;
  endfunction

  // Spans and doubled offsets from the frame center.
  always_comb begin
    h   = {cfg.z_max[CW-1], cfg.z_max} - {cfg.z_min[CW-1], cfg.z_min};
    hx2 = {cfg.x_max[CW-1], cfg.x_max} - {cfg.x_min[CW-1], cfg.x_min};
    hy2 = {cfg.y_max[CW-1], cfg.y_max} - {cfg.y_min[CW-1], cfg.y_min};
    r2s = ($signed(hx2) < $signed(hy2)) ? hx2 : hy2;
    dx2 = {px[CW-1], px, 1'b0} - ({{2{cfg.x_min[CW-1]}}, cfg.x_min} +
                                  {{2{cfg.x_max[CW-1]}}, cfg.x_max});
    dy2 = {py[CW-1], py, 1'b0} - ({{2{cfg.y_min[CW-1]}}, cfg.y_min} +
                                  {{2{cfg.y_max[CW-1]}}, cfg.y_max});
    dz2 = {pz[CW-1], pz, 1'b0} - ({{2{cfg.z_min[CW-1]}}, cfg.z_min} +
                                  {{2{cfg.z_max[CW-1]}}, cfg.z_max});
    ge   = $signed(pz) >= $signed(cfg.z_min);
    inz  = ge && ($signed(pz) <= $signed(cfg.z_max));
    up_w = {cfg.z_max[CW-1], cfg.z_max} - {pz[CW-1], pz};
    u_w  = {pz[CW-1], pz} - {cfg.z_min[CW-1], cfg.z_min};
  end

  // Bump mode clamped to -1..1 and the scaled limit factor.
  always_comb begin
    mf       = cfg.bump[63:48];
    mneg     = mf[15];
    mneg_abs = 16'd0 - mf;
    if (mneg) begin
      mabs = (mneg_abs > QONE16) ? QONE15 : mneg_abs[14:0];
    end else begin
      mabs = (mf > QONE16) ? QONE15 : mf[14:0];
    end
  end

  always_comb begin
    q_nxt.b  = clamp01(cfg.bump[15:0]);
    q_nxt.rx = clamp01(cfg.bump[31:16]);
    q_nxt.ry = clamp01(cfg.bump[47:32]);
    kneg = 30'(q_nxt.b) * 30'(QONE15 - mabs);
    kpos = 30'({q_nxt.b, 14'd0}) + 30'(mabs) * 30'(QONE15 - q_nxt.b);
    q_nxt.kk = mneg ? kneg[28:0] : kpos[28:0];

    q_nxt.ax     = dx2[33] ? (34'd0 - dx2) : dx2;
    q_nxt.ay     = dy2[33] ? (34'd0 - dy2) : dy2;
    q_nxt.az     = dz2[33] ? (34'd0 - dz2) : dz2;
    q_nxt.hu     = h[31:0];
    q_nxt.hxneg  = hx2[32];
    q_nxt.hyneg  = hy2[32];
    q_nxt.hxm    = hx2[32] ? 32'd0 : hx2[31:0];
    q_nxt.hym    = hy2[32] ? 32'd0 : hy2[31:0];
    q_nxt.rmag   = r2s[32] ? (33'd0 - r2s) : r2s;
    q_nxt.up     = inz ? up_w[31:0] : 32'd0;
    q_nxt.u      = ge ? u_w[31:0] : 32'd0;
    q_nxt.ge     = ge;
    q_nxt.inz    = inz;
    q_nxt.active = (cfg.shape_mode != SHAPE_BOX) && (cfg.shape_mode <= SHAPE_BUMP) &&
                   !h[32] && (h != 33'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// File: rtl/pist_prod.sv
// ----------------------------------------------------------------------------
// Point-in-solid test: product and decision stages
// Registers the first-level products, then decides every solid but the cone.
// ----------------------------------------------------------------------------
module pist_prod
  import pist_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [2:0] shape_mode,
  input  prep_t      p,
  output dec_t       d_r
);

  prod_t       m_nxt;
  prod_t       m_r;
  dec_t        d_nxt;
  logic        sph;
  logic        cyl;
  logic        wx;
  logic        wy;
  logic        wbx;
  logic        wby;
  logic        cmp1;
  logic        cmp2;
  logic        pyr;
  logic        bump;

  // Products of offsets and spans, one multiplier per term.
  always_comb begin
    m_nxt.sqx    = 68'(p.ax) * 68'(p.ax);
    m_nxt.sqy    = 68'(p.ay) * 68'(p.ay);
    m_nxt.sqz    = 68'(p.az) * 68'(p.az);
    m_nxt.hsq    = 64'(p.hu) * 64'(p.hu);
    m_nxt.rsq    = 66'(p.rmag) * 66'(p.rmag);
    m_nxt.tt     = 65'(p.up) * 65'(p.rmag);
    m_nxt.pxl    = 66'(p.ax) * 66'(p.hu);
    m_nxt.pyl    = 66'(p.ay) * 66'(p.hu);
    m_nxt.pxr    = 64'(p.up) * 64'(p.hxm);
    m_nxt.pyr    = 64'(p.up) * 64'(p.hym);
    m_nxt.bxr    = 47'(p.rx) * 47'(p.hxm);
    m_nxt.byr    = 47'(p.ry) * 47'(p.hym);
    m_nxt.bbh    = 47'(p.b) * 47'(p.hu);
    m_nxt.hk     = 61'(p.hu) * 61'(p.kk);
    m_nxt.ax     = p.ax;
    m_nxt.ay     = p.ay;
    m_nxt.u      = p.u;
    m_nxt.axz    = (p.ax == 34'd0);
    m_nxt.ayz    = (p.ay == 34'd0);
    m_nxt.upz    = (p.up == 32'd0);
    m_nxt.rxz    = (p.rx == 15'd0);
    m_nxt.ryz    = (p.ry == 15'd0);
    m_nxt.hxneg  = p.hxneg;
    m_nxt.hyneg  = p.hyneg;
    m_nxt.inz    = p.inz;
    m_nxt.ge     = p.ge;
    m_nxt.active = p.active;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
    end
  end

  // Compares for all solids except the cone. A negative half-width admits
  // only a centered point at a zero limit.
  always_comb begin
    d_nxt.rr  = 69'(m_r.sqx) + 69'(m_r.sqy);
    d_nxt.hsq = m_r.hsq;
    d_nxt.tt  = m_r.tt;
    d_nxt.inz = m_r.inz;
    sph  = (70'(d_nxt.rr) + 70'(m_r.sqz)) <= 70'(m_r.hsq);
    cyl  = m_r.inz && (d_nxt.rr <= 69'(m_r.rsq));
    wx   = m_r.hxneg ? (m_r.axz && m_r.upz) : (m_r.pxl <= 66'(m_r.pxr));
    wy   = m_r.hyneg ? (m_r.ayz && m_r.upz) : (m_r.pyl <= 66'(m_r.pyr));
    pyr  = m_r.inz && wx && wy;
    wbx  = m_r.hxneg ? (m_r.axz && m_r.rxz) : (48'({m_r.ax, 14'd0}) <= 48'(m_r.bxr));
    wby  = m_r.hyneg ? (m_r.ayz && m_r.ryz) : (48'({m_r.ay, 14'd0}) <= 48'(m_r.byr));
    cmp1 = 47'({m_r.u, 14'd0}) <= m_r.bbh;
    cmp2 = 61'({m_r.u, 28'd0}) <= m_r.hk;
    bump = m_r.ge && ((wbx && wby) ? cmp2 : cmp1);
    d_nxt.cone_sel = 1'b0;
    if (!m_r.active) begin
      d_nxt.res = 1'b1;
    end else begin
      unique case (shape_mode)
        SHAPE_PYRAMID:  d_nxt.res = pyr;
        SHAPE_CONE: begin
          d_nxt.res      = 1'b0;
          d_nxt.cone_sel = 1'b1;
        end
        SHAPE_SPHERE:   d_nxt.res = sph;
        SHAPE_CYLINDER: d_nxt.res = cyl;
        SHAPE_BUMP:     d_nxt.res = bump;
        default:        d_nxt.res = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

// File: rtl/pist_wmul.sv
// ----------------------------------------------------------------------------
// Point-in-solid test: wide multiplier
// 70 x 70 unsigned product over three stages of 18-bit limbs.
// ----------------------------------------------------------------------------
module pist_wmul
  import pist_pkg::*;
(
  input  logic         clk,
  input  logic         en,
  input  logic [69:0]  a,
  input  logic [69:0]  b,
  output logic [139:0] p_r
);

  logic [71:0]  ae;
  logic [71:0]  be;
  logic [35:0]  pp_nxt  [4][4];
  logic [35:0]  pp_r    [4][4];
  logic [107:0] row_nxt [4];
  logic [107:0] row_r   [4];
  logic [143:0] sum_nxt;

  // Partial products of limb pairs.
  always_comb begin
    ae = {2'b00, a};
    be = {2'b00, b};
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pp_nxt[i][j] = 36'(ae[18*i +: 18]) * 36'(be[18*j +: 18]);
      end
    end
  end

  // Row sums, then the final sum of shifted rows.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      row_nxt[i] = 108'(pp_r[i][0]) + (108'(pp_r[i][1]) << 18) +
                   (108'(pp_r[i][2]) << 36) + (108'(pp_r[i][3]) << 54);
    end
    sum_nxt = 144'(row_r[0]) + (144'(row_r[1]) << 18) +
              (144'(row_r[2]) << 36) + (144'(row_r[3]) << 54);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r  <= pp_nxt;
      row_r <= row_nxt;
      p_r   <= sum_nxt[139:0];
    end
  end

endmodule

// File: rtl/point_in_solid_shape_test_core.sv
// ----------------------------------------------------------------------------
// Point-in-solid test core
// Decides whether a Q16.16 point lies inside the configured solid.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  in_     | slave     | tdata: point_x [31:0], point_y [63:32], point_z [95:64]
//  out_    | master    | tdata: is_inside [0], zero fill [7:1]
//  cfg_    | write     | index 0..7, data up to 64 bits
//
// One point enters per cycle while the output is not stalled; its result leaves
// through the stage chain: input register, offsets, products, decision, three
// stages of the wide cone multiplier, output register.
// Reset clears the valid bits and all configuration registers.
// A stalled output holds the whole chain; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module point_in_solid_shape_test_core
  import pist_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // point_x, point_y, point_z from bit 0 up
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // is_inside, then zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t          cfg_r;
  logic [7:0]    vld_r;
  logic          en;
  logic [CW-1:0] px_r;
  logic [CW-1:0] py_r;
  logic [CW-1:0] pz_r;
  prep_t         prep_q;
  dec_t          dec_q;
  logic [139:0]  lhs;
  logic [139:0]  rhs;
  logic [2:0]    res_d_r;
  logic [2:0]    cone_d_r;
  logic [2:0]    inz_d_r;
  logic          out_nxt;
  logic          out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SHAPE_MODE:  cfg_r.shape_mode <= cfg_data[2:0];
        REG_BOUND_X_MIN: cfg_r.x_min      <= cfg_data[CW-1:0];
        REG_BOUND_X_MAX: cfg_r.x_max      <= cfg_data[CW-1:0];
        REG_BOUND_Y_MIN: cfg_r.y_min      <= cfg_data[CW-1:0];
        REG_BOUND_Y_MAX: cfg_r.y_max      <= cfg_data[CW-1:0];
        REG_BOUND_Z_MIN: cfg_r.z_min      <= cfg_data[CW-1:0];
        REG_BOUND_Z_MAX: cfg_r.z_max      <= cfg_data[CW-1:0];
        REG_BUMP_PARAMS: cfg_r.bump       <= cfg_data;
        default: ;
      endcase
    end
  end

  // The chain advances unless a finished result is held at the output.
  // No transaction is taken while reset is held.
  assign en        = !vld_r[7] || out_tready;
  assign in_tready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], in_tvalid};
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= in_tdata[31:0];
      py_r <= in_tdata[63:32];
      pz_r <= in_tdata[95:64];
    end
  end

  pist_prep u_prep (
    .clk (clk),
    .en  (en),
    .cfg (cfg_r),
    .px  (px_r),
    .py  (py_r),
    .pz  (pz_r),
    .q_r (prep_q)
  );

  pist_prod u_prod (
    .clk        (clk),
    .en         (en),
    .shape_mode (cfg_r.shape_mode),
    .p          (prep_q),
    .d_r        (dec_q)
  );

  // Cone test: squared radial distance times H squared against t squared.
  pist_wmul u_mul_lhs (
    .clk (clk),
    .en  (en),
    .a   (70'(dec_q.rr)),
    .b   (70'(dec_q.hsq)),
    .p_r (lhs)
  );

  pist_wmul u_mul_rhs (
    .clk (clk),
    .en  (en),
    .a   (70'(dec_q.tt)),
    .b   (70'(dec_q.tt)),
    .p_r (rhs)
  );

  // Decision bits ride alongside the multiplier stages.
  always_ff @(posedge clk) begin
    if (en) begin
      res_d_r  <= {res_d_r[1:0], dec_q.res};
      cone_d_r <= {cone_d_r[1:0], dec_q.cone_sel};
      inz_d_r  <= {inz_d_r[1:0], dec_q.inz};
    end
  end

  // Output register.
  assign out_nxt = cone_d_r[2] ? (inz_d_r[2] && (lhs <= rhs)) : res_d_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = vld_r[7];
  assign out_tdata  = {7'd0, out_r};

endmodule
